// File: src/mersenne_twister_word_generator_assert.svh
// Assertion macros shared by the generator RTL.
`ifndef MERSENNE_TWISTER_WORD_GENERATOR_ASSERT_SVH
`define MERSENNE_TWISTER_WORD_GENERATOR_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define MTG_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, checked out of reset.
`define MTG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MTG_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define MTG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: src/mtg_pkg.sv
// Constants, types and word functions of the MT19937 word generator.
package mtg_pkg;

  localparam int STATE_WORDS  = 624;
  localparam int SHIFT_OFFSET = 397;
  localparam int IDX_W        = 10;
  localparam int WORD_W       = 32;

  localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_B0DF;
  localparam logic [IDX_W-1:0]  LAST_IDX     = IDX_W'(STATE_WORDS - 1);
  localparam logic [IDX_W-1:0]  POS_FULL     = IDX_W'(STATE_WORDS);
  localparam logic [IDX_W-1:0]  FAR_WRAP     = IDX_W'(STATE_WORDS - SHIFT_OFFSET);
  localparam logic [IDX_W-1:0]  FAR_OFFSET   = IDX_W'(SHIFT_OFFSET);

  typedef enum logic [1:0] {
    MODE_GEN    = 2'd0,
    MODE_LOAD   = 2'd1,
    MODE_SETPOS = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TW_PRE,
    S_TW_B,
    S_TW_C,
    S_OUT_RD
  } state_t;

  function automatic logic [WORD_W-1:0] twist(input logic [WORD_W-1:0] head,
                                                 input logic [WORD_W-1:0] follow,
                                                 input logic [WORD_W-1:0] far);
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] v;
    y = {head[WORD_W-1], follow[WORD_W-2:0]};
    v = far ^ (y >> 1);
    if (y[0]) v = v ^ TWIST_MATRIX;
    return v;
  endfunction

  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & 32'h9D2C_5680);
    y = y ^ ((y << 15) & 32'hEFC6_0000);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

// File: src/mtg_in_if.sv
// Command channel of the word generator.
interface mtg_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    mode;
  logic [mtg_pkg::IDX_W-1:0]     load_index;
  logic [mtg_pkg::WORD_W-1:0]    load_word;
  logic [mtg_pkg::IDX_W-1:0]     position;

  modport source (output valid, output mode, output load_index, output load_word,
                  output position, input ready);
  modport sink   (input valid, input mode, input load_index, input load_word,
                  input position, output ready);
endinterface

// File: src/mtg_out_if.sv
// Result channel of the word generator.
interface mtg_out_if;
  logic                          valid;
  logic                          ready;
  logic [mtg_pkg::WORD_W-1:0]    random_word;

  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface

// File: src/mersenne_twister_word_generator.sv
// MT19937 word generator: 624-word state RAM, twist sequencer and tempering output.
// Generate with position below 624: the state word at that position is read and tempered
//   into the result register; no new command is taken until that result is registered.
// Generate with position 624: a twist pass over all state words (read next, read far,
//   write back), then word 0 is output. Load and set-position are handled in idle.
// Reset (synchronous, rst_n low) sets position to 624; the state RAM is not cleared.
`include "mersenne_twister_word_generator_assert.svh"

module mersenne_twister_word_generator (
  input  logic       clk,
  input  logic       rst_n,
  mtg_in_if.sink     in_ch,
  mtg_out_if.source  out_ch
);

  localparam int IW = mtg_pkg::IDX_W;
  localparam int WW = mtg_pkg::WORD_W;

  mtg_pkg::state_t state_r, state_nxt;
  logic [IW-1:0]   k_r, k_nxt;
  logic [IW-1:0]   pos_r, pos_nxt;
  logic [WW-1:0]   head_word_r, head_word_nxt;
  logic [WW-1:0]   next_word_r, next_word_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [WW-1:0]   out_word_r, out_word_nxt;

  logic            rd_en;
  logic [IW-1:0]   rd_addr;
  logic [WW-1:0]   rd_data;
  logic            wr_en;
  logic [IW-1:0]   wr_addr;
  logic [WW-1:0]   wr_data;
  logic [IW-1:0]   far_idx;

  mtg_ram #(
    .WIDTH (WW),
    .DEPTH (mtg_pkg::STATE_WORDS),
    .AW    (IW)
  ) u_state_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Partner word k+397, wrapped into the already rewritten low part.
  assign far_idx = (k_r < mtg_pkg::FAR_WRAP) ? (k_r + mtg_pkg::FAR_OFFSET)
                                             : (k_r - mtg_pkg::FAR_WRAP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mtg_pkg::S_IDLE;
      k_r         <= '0;
      pos_r       <= mtg_pkg::POS_FULL;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_word_r <= head_word_nxt;
    next_word_r <= next_word_nxt;
    out_word_r  <= out_word_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    pos_nxt       = pos_r;
    head_word_nxt = head_word_r;
    next_word_nxt = next_word_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_word_nxt  = out_word_r;
    rd_en         = 1'b0;
    rd_addr       = k_r;
    wr_en         = 1'b0;
    wr_addr       = k_r;
    wr_data       = mtg_pkg::twist(head_word_r, next_word_r, rd_data);
    in_ch.ready   = 1'b0;

    case (state_r)
      mtg_pkg::S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          case (mtg_pkg::mode_t'(in_ch.mode))
            mtg_pkg::MODE_LOAD: begin
              if (in_ch.load_index < mtg_pkg::POS_FULL) begin
                wr_en   = 1'b1;
                wr_addr = in_ch.load_index;
                wr_data = in_ch.load_word;
              end
            end
            mtg_pkg::MODE_SETPOS: begin
              pos_nxt = (in_ch.position >= mtg_pkg::POS_FULL) ? mtg_pkg::POS_FULL
                                                               : in_ch.position;
            end
            mtg_pkg::MODE_GEN: begin
              rd_en = 1'b1;
              if (pos_r >= mtg_pkg::POS_FULL) begin
                rd_addr   = '0;
                k_nxt     = '0;
                state_nxt = mtg_pkg::S_TW_PRE;
              end else begin
                rd_addr   = pos_r;
                state_nxt = mtg_pkg::S_OUT_RD;
              end
            end
            default: ;
          endcase
        end
      end
      mtg_pkg::S_TW_PRE: begin
        // Old word 0 arrives; fetch old word 1.
        head_word_nxt = rd_data;
        rd_en         = 1'b1;
        rd_addr       = k_r + IW'(1);
        state_nxt     = mtg_pkg::S_TW_B;
      end
      mtg_pkg::S_TW_B: begin
        next_word_nxt = rd_data;
        rd_en         = 1'b1;
        rd_addr       = far_idx;
        state_nxt     = mtg_pkg::S_TW_C;
      end
      mtg_pkg::S_TW_C: begin
        // Write back word k and fetch the follower of word k+1 in the same cycle.
        wr_en         = 1'b1;
        head_word_nxt = next_word_r;
        rd_en         = 1'b1;
        if (k_r == mtg_pkg::LAST_IDX) begin
          rd_addr   = '0;
          pos_nxt   = '0;
          state_nxt = mtg_pkg::S_OUT_RD;
        end else begin
          k_nxt     = k_r + IW'(1);
          rd_addr   = (k_r + IW'(1) == mtg_pkg::LAST_IDX) ? '0 : (k_r + IW'(2));
          state_nxt = mtg_pkg::S_TW_B;
        end
      end
      mtg_pkg::S_OUT_RD: begin
        // Hold the read data until the output register frees up.
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = mtg_pkg::temper(rd_data);
          pos_nxt       = pos_r + IW'(1);
          state_nxt     = mtg_pkg::S_IDLE;
        end
      end
      default: state_nxt = mtg_pkg::S_IDLE;
    endcase
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.random_word = out_word_r;

  `MTG_ASSERT_NOW(a_no_rw_collide, clk, rst_n, wr_en && rd_en, wr_addr != rd_addr)
  `MTG_ASSERT_NOW(a_pos_bound, clk, rst_n, 1'b1, pos_r <= mtg_pkg::POS_FULL)
  `MTG_ASSERT_NEXT(a_twist_end, clk, rst_n,
    state_r == mtg_pkg::S_TW_C && k_r == mtg_pkg::LAST_IDX,
    state_r == mtg_pkg::S_OUT_RD && pos_r == '0)
  `MTG_ASSERT_NEXT(a_gen_direct, clk, rst_n,
    state_r == mtg_pkg::S_IDLE && in_ch.valid && in_ch.mode == mtg_pkg::MODE_GEN
      && pos_r < mtg_pkg::POS_FULL,
    state_r == mtg_pkg::S_OUT_RD)

endmodule

// File: src/mtg_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mtg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 624,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
